>>> hdl/mhrs_pkg.sv
package mhrs_pkg;

	// Request command codes.
	localparam logic [1:0] CMD_READ    = 2'd0;
	localparam logic [1:0] CMD_WSINGLE = 2'd1;
	localparam logic [1:0] CMD_WMULTI  = 2'd2;

	// Function codes placed in responses.
	localparam logic [7:0] FC_READ    = 8'd3;
	localparam logic [7:0] FC_WSINGLE = 8'd6;
	localparam logic [7:0] FC_WMULTI  = 8'd16;

	// Exception kinds.
	localparam logic [1:0] EXC_NONE    = 2'd0;
	localparam logic [1:0] EXC_ADDRESS = 2'd1;
	localparam logic [1:0] EXC_VALUE   = 2'd2;

	// Station address after reset, also held by the identity slot of the table.
	localparam logic [7:0] SERVER_ID_RESET = 8'd1;

	// Operands of the shared add and compare unit: sum = a + b, compared with c.
	typedef struct packed {
		logic [15:0] a;
		logic [15:0] b;
		logic [16:0] c;
	} alu_op_t;

	// Result of the shared unit.
	typedef struct packed {
		logic [16:0] sum;
		logic        lt;
		logic        eq;
	} alu_res_t;

	// One response result as held in the output register.
	typedef struct packed {
		logic [7:0]  station;
		logic [7:0]  function_code;
		logic        is_exception;
		logic [1:0]  exception_kind;
		logic [15:0] echo_address;
		logic [15:0] echo_word;
		logic [7:0]  data_byte_count;
		logic [15:0] data_word;
		logic        data_valid;
		logic        last;
	} rsp_t;

endpackage

>>> hdl/mhrs_if.sv
// Decoded request channel.
interface mhrs_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] start_address;
	logic [15:0] quantity;
	logic [7:0]  byte_count;
	logic [7:0]  word_position;
	logic [15:0] value;

	modport source (output valid, command, start_address, quantity, byte_count,
		word_position, value, input ready);
	modport sink (input valid, command, start_address, quantity, byte_count,
		word_position, value, output ready);
endinterface

// Response result channel.
interface mhrs_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  station;
	logic [7:0]  function_code;
	logic        is_exception;
	logic [1:0]  exception_kind;
	logic [15:0] echo_address;
	logic [15:0] echo_word;
	logic [7:0]  data_byte_count;
	logic [15:0] data_word;
	logic        data_valid;
	logic        last;

	modport source (output valid, station, function_code, is_exception, exception_kind,
		echo_address, echo_word, data_byte_count, data_word, data_valid, last,
		input ready);
	modport sink (input valid, station, function_code, is_exception, exception_kind,
		echo_address, echo_word, data_byte_count, data_word, data_valid, last,
		output ready);
endinterface

// Station address write channel.
interface mhrs_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> hdl/mhrs_ram.sv
module mhrs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port; read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/mhrs_alu.sv
module mhrs_alu (
	input  mhrs_pkg::alu_op_t  op,
	output mhrs_pkg::alu_res_t res
);
	import mhrs_pkg::*;

	logic [16:0] sum;

	// A 17-bit sum, so range checks never wrap, compared against the limit.
	always_comb begin
		sum     = {1'b0, op.a} + {1'b0, op.b};
		res.sum = sum;
		res.lt  = sum < op.c;
		res.eq  = sum == op.c;
	end

endmodule

>>> hdl/modbus_holding_register_server.sv
// Holding-register server for decoded requests. One request is taken at a time and
// request.ready is high only while the sequencer is idle. Every check and address sum
// goes through one shared 17-bit add and compare unit, one step per cycle unless a
// result stalls on a full output register, and the table sits in a single-port-write,
// registered-read RAM. A read of N registers runs two checks, then an address step and
// a result step per word; a write single runs one bound check with the write and the
// result; a write-multiple word runs up to three checks on word 0, or the failure gate
// on a later word, then a position check, an index check with the write and the echo
// decision. The next request is taken in the idle state that follows. The output
// register lets the next request be taken while the last result still waits; a
// result that finds it full stalls the sequencer. Station address writes are always
// taken and, when the identity slot lies in the table, mirror the value into it. The
// table needs no clearing pass: one valid flag per entry makes unwritten entries
// read as their reset value.
module modbus_holding_register_server #(
	parameter int TABLE_DEPTH = 64,
	parameter int ID_SLOT = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	mhrs_cfg_if.sink   cfg,
	mhrs_req_if.sink   request,
	mhrs_rsp_if.source response
);
	import mhrs_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [16:0] DEPTH_LIM = 17'(TABLE_DEPTH);
	localparam bit ID_IN = ID_SLOT < TABLE_DEPTH;
	localparam logic [AW-1:0] ID_ADDR = AW'(ID_SLOT);

	// Sequencer states.
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_ZERO     = 4'd1;
	localparam logic [3:0] S_RANGE    = 4'd2;
	localparam logic [3:0] S_BCNT     = 4'd3;
	localparam logic [3:0] S_WM_GATE  = 4'd4;
	localparam logic [3:0] S_WM_POS   = 4'd5;
	localparam logic [3:0] S_WM_IDX   = 4'd6;
	localparam logic [3:0] S_WM_LAST  = 4'd7;
	localparam logic [3:0] S_WS_BOUND = 4'd8;
	localparam logic [3:0] S_RD_ADDR  = 4'd9;
	localparam logic [3:0] S_RD_EMIT  = 4'd10;

	logic [3:0]       state_q, state_d;
	logic [1:0]       cmd_q;
	logic [15:0]      start_q, qty_q, val_q;
	logic [7:0]       bcount_q, pos_q;
	logic [CNT_W-1:0] k_q, k_d;
	logic             mwf_q, set_fail, clr_fail;
	logic [7:0]       server_id_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic             rd_hit_q, rd_id_q;

	logic             out_v_q, out_free, emit;
	rsp_t             out_q, rsp_d;
	logic [7:0]       fc_cur;

	alu_op_t          alu_op;
	alu_res_t         alu_res;
	logic             gt;

	logic             fsm_we, cfg_we, ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [15:0]      fsm_wdata, ram_wdata, ram_rdata, rd_word;

	mhrs_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	mhrs_ram #(
		.WIDTH (16),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign gt = !alu_res.lt && !alu_res.eq;
	assign out_free = !out_v_q || response.ready;
	assign request.ready = state_q == S_IDLE;
	assign cfg.ready = 1'b1;

	// Function code of the request in hand.
	always_comb begin
		unique case (cmd_q)
			CMD_READ:    fc_cur = FC_READ;
			CMD_WSINGLE: fc_cur = FC_WSINGLE;
			default:     fc_cur = FC_WMULTI;
		endcase
	end

	// Operands of the shared unit for each sequencer step.
	always_comb begin
		alu_op.a = qty_q;
		alu_op.b = '0;
		alu_op.c = '0;
		unique case (state_q)
			S_RANGE: begin
				alu_op.a = start_q;
				alu_op.b = qty_q;
				alu_op.c = DEPTH_LIM;
			end
			S_BCNT: begin
				alu_op.a = qty_q;
				alu_op.b = qty_q;
				alu_op.c = {9'd0, bcount_q};
			end
			S_WM_POS: begin
				alu_op.a = {8'd0, pos_q};
				alu_op.c = {1'b0, qty_q};
			end
			S_WM_IDX: begin
				alu_op.a = start_q;
				alu_op.b = {8'd0, pos_q};
				alu_op.c = DEPTH_LIM;
			end
			S_WM_LAST: begin
				alu_op.a = {8'd0, pos_q};
				alu_op.b = 16'd1;
				alu_op.c = {1'b0, qty_q};
			end
			S_WS_BOUND, S_RD_ADDR: begin
				alu_op.a = start_q;
				alu_op.b = (state_q == S_RD_ADDR) ? 16'(k_q) : 16'd0;
				alu_op.c = DEPTH_LIM;
			end
			S_RD_EMIT: begin
				alu_op.a = 16'(k_q);
				alu_op.b = 16'd1;
				alu_op.c = {1'b0, qty_q};
			end
			default: begin
			end
		endcase
	end

	// An entry never written reads as its reset value.
	assign rd_word = rd_hit_q ? ram_rdata : (rd_id_q ? 16'(SERVER_ID_RESET) : 16'd0);

	// Sequencer: next state, table access and the result to emit.
	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		emit      = 1'b0;
		set_fail  = 1'b0;
		clr_fail  = 1'b0;
		fsm_we    = 1'b0;
		fsm_wdata = val_q;
		ram_re    = 1'b0;
		ram_raddr = alu_res.sum[AW-1:0];

		rsp_d                 = '0;
		rsp_d.station         = server_id_q;
		rsp_d.function_code   = fc_cur;
		rsp_d.is_exception    = 1'b1;
		rsp_d.exception_kind  = EXC_VALUE;
		rsp_d.last            = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				k_d = '0;
				if (request.valid) begin
					unique case (request.command)
						CMD_READ:    state_d = S_ZERO;
						CMD_WSINGLE: state_d = S_WS_BOUND;
						CMD_WMULTI:  state_d = (request.word_position == 8'd0) ?
							S_ZERO : S_WM_GATE;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_ZERO: begin
				if (out_free) begin
					if (alu_res.eq) begin
						emit     = 1'b1;
						set_fail = cmd_q == CMD_WMULTI;
						state_d  = S_IDLE;
					end else begin
						state_d = S_RANGE;
					end
				end
			end
			S_RANGE: begin
				rsp_d.exception_kind = EXC_ADDRESS;
				if (out_free) begin
					if (gt) begin
						emit     = 1'b1;
						set_fail = cmd_q == CMD_WMULTI;
						state_d  = S_IDLE;
					end else begin
						state_d = (cmd_q == CMD_READ) ? S_RD_ADDR : S_BCNT;
					end
				end
			end
			S_BCNT: begin
				if (out_free) begin
					if (!alu_res.eq) begin
						emit     = 1'b1;
						set_fail = 1'b1;
						state_d  = S_IDLE;
					end else begin
						clr_fail = 1'b1;
						state_d  = S_WM_POS;
					end
				end
			end
			S_WM_GATE: begin
				state_d = mwf_q ? S_IDLE : S_WM_POS;
			end
			S_WM_POS: begin
				state_d = alu_res.lt ? S_WM_IDX : S_IDLE;
			end
			S_WM_IDX: begin
				if (alu_res.lt) begin
					fsm_we  = 1'b1;
					state_d = S_WM_LAST;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_WM_LAST: begin
				rsp_d.is_exception   = 1'b0;
				rsp_d.exception_kind = EXC_NONE;
				rsp_d.echo_address   = start_q;
				rsp_d.echo_word      = qty_q;
				if (out_free) begin
					emit    = alu_res.eq;
					state_d = S_IDLE;
				end
			end
			S_WS_BOUND: begin
				if (alu_res.lt) begin
					rsp_d.is_exception   = 1'b0;
					rsp_d.exception_kind = EXC_NONE;
					rsp_d.echo_address   = start_q;
					rsp_d.echo_word      = val_q;
				end else begin
					rsp_d.exception_kind = EXC_ADDRESS;
				end
				if (out_free) begin
					emit    = 1'b1;
					fsm_we  = alu_res.lt;
					state_d = S_IDLE;
				end
			end
			S_RD_ADDR: begin
				ram_re  = 1'b1;
				state_d = S_RD_EMIT;
			end
			S_RD_EMIT: begin
				rsp_d.is_exception    = 1'b0;
				rsp_d.exception_kind  = EXC_NONE;
				rsp_d.data_byte_count = 8'({qty_q, 1'b0});
				rsp_d.data_word       = rd_word;
				rsp_d.data_valid      = 1'b1;
				rsp_d.last            = alu_res.eq;
				if (out_free) begin
					emit = 1'b1;
					if (alu_res.eq) begin
						state_d = S_IDLE;
					end else begin
						k_d     = CNT_W'(k_q + 1'b1);
						state_d = S_RD_ADDR;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Table write port: a station address write mirrors into the identity slot when it lies in the table.
	assign cfg_we    = cfg.valid && cfg.ready && ID_IN;
	assign ram_we    = cfg_we || fsm_we;
	assign ram_waddr = cfg_we ? ID_ADDR : alu_res.sum[AW-1:0];
	assign ram_wdata = cfg_we ? {8'd0, cfg.data} : fsm_wdata;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_v_q     <= 1'b0;
			mwf_q       <= 1'b0;
			server_id_q <= SERVER_ID_RESET;
			valid_q     <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (response.ready) begin
				out_v_q <= 1'b0;
			end
			if (set_fail) begin
				mwf_q <= 1'b1;
			end else if (clr_fail) begin
				mwf_q <= 1'b0;
			end
			if (cfg.valid && cfg.ready) begin
				server_id_q <= cfg.data;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
		end
	end

	// Request fields, loop counter, read flags and the output register.
	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			cmd_q    <= request.command;
			start_q  <= request.start_address;
			qty_q    <= request.quantity;
			bcount_q <= request.byte_count;
			pos_q    <= request.word_position;
			val_q    <= request.value;
		end
		k_q <= k_d;
		if (ram_re) begin
			rd_hit_q <= valid_q[ram_raddr];
			rd_id_q  <= ID_IN && (ram_raddr == ID_ADDR);
		end
		if (emit) begin
			out_q <= rsp_d;
		end
	end

	assign response.valid           = out_v_q;
	assign response.station         = out_q.station;
	assign response.function_code   = out_q.function_code;
	assign response.is_exception    = out_q.is_exception;
	assign response.exception_kind  = out_q.exception_kind;
	assign response.echo_address    = out_q.echo_address;
	assign response.echo_word       = out_q.echo_word;
	assign response.data_byte_count = out_q.data_byte_count;
	assign response.data_word       = out_q.data_word;
	assign response.data_valid      = out_q.data_valid;
	assign response.last            = out_q.last;

endmodule
